### hdl/led_burst_blink_sequencer_defines.svh
// ----------------------------------------------------------------------------
// led burst blink sequencer assertion macros
// wrappers that vanish when the design is synthesised
// ----------------------------------------------------------------------------
`ifndef LED_BURST_BLINK_SEQUENCER_DEFINES_SVH
`define LED_BURST_BLINK_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS

// checked only while reset is released
`define LBBS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define LBBS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define LBBS_ASSERT(lbl, prop, msg)
`define LBBS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### hdl/lbbs_pkg.sv
// ----------------------------------------------------------------------------
// lbbs_pkg
// shared types and codes of the led burst blink sequencer
// ----------------------------------------------------------------------------
package lbbs_pkg;

    localparam int FUNC_W  = 2;
    localparam int COUNT_W = 8;
    localparam int MS_W    = 16;

    // item kinds
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_BURST = 2'd1,
        FUNC_CONT  = 2'd2,
        FUNC_STOP  = 2'd3
    } t_func;

    typedef struct packed {
        t_func               func;
        logic [COUNT_W-1:0]  blink_count;
        logic [MS_W-1:0]     on_ms;
        logic [MS_W-1:0]     off_ms;
    } t_item;

    typedef struct packed {
        logic                running;
        logic [COUNT_W-1:0]  blinks_left;
        logic                pin_level;
        logic                led_on;
    } t_result;

endpackage

### hdl/lbbs_core.sv
// ----------------------------------------------------------------------------
// lbbs_core
// blink state registers and the single-pass update for one item
// ----------------------------------------------------------------------------
module lbbs_core #(
    parameter int TIME_BITS  = 16,
    parameter int COUNT_BITS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  lbbs_pkg::t_item  i_item,
    input  logic             i_active_level,
    output lbbs_pkg::t_result o_result
);
    import lbbs_pkg::*;

    localparam int TB = TIME_BITS;
    localparam int CB = COUNT_BITS;

    logic          r_lit,        n_lit;
    logic [TB-1:0] r_elapsed,    n_elapsed;
    logic [CB-1:0] r_burst_left, n_burst_left;
    logic          r_cont,       n_cont;
    logic [TB-1:0] r_phase_on,   n_phase_on;
    logic [TB-1:0] r_phase_off,  n_phase_off;
    logic [TB-1:0] r_rep_on,     n_rep_on;
    logic [TB-1:0] r_rep_off,    n_rep_off;

    logic [TB-1:0] on_t;
    logic [TB-1:0] off_t;
    logic [TB-1:0] off_eff;
    logic [TB-1:0] elapsed_inc;
    logic [TB-1:0] wait_ms;

    assign on_t        = TB'(i_item.on_ms);
    assign off_t       = TB'(i_item.off_ms);
    assign off_eff     = (off_t != '0) ? off_t : on_t;
    // saturating ms counter
    assign elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + TB'(1);
    assign wait_ms     = r_lit ? r_phase_on : r_phase_off;

    always_comb begin
        n_lit        = r_lit;
        n_elapsed    = r_elapsed;
        n_burst_left = r_burst_left;
        n_cont       = r_cont;
        n_phase_on   = r_phase_on;
        n_phase_off  = r_phase_off;
        n_rep_on     = r_rep_on;
        n_rep_off    = r_rep_off;
        unique case (i_item.func)
            FUNC_TICK: begin
                if (r_burst_left != '0 || r_cont) begin
                    if (elapsed_inc >= wait_ms) begin
                        n_elapsed = elapsed_inc - wait_ms;
                        n_lit     = ~r_lit;
                        // a blink completes on the toggle to dark
                        if (r_lit && r_burst_left != '0) begin
                            n_burst_left = r_burst_left - CB'(1);
                            if (r_burst_left == CB'(1) && r_cont) begin
                                n_phase_on  = r_rep_on;
                                n_phase_off = r_rep_off;
                            end
                        end
                    end else begin
                        n_elapsed = elapsed_inc;
                    end
                end
            end
            FUNC_BURST, FUNC_CONT: begin
                n_burst_left = (i_item.func == FUNC_BURST) ? CB'(i_item.blink_count) : '0;
                n_phase_on   = on_t;
                n_phase_off  = off_eff;
                // dark start lights on the next tick
                n_elapsed    = r_lit ? '0 : off_eff;
                n_lit        = 1'b0;
                if (i_item.func == FUNC_CONT) begin
                    n_cont    = 1'b1;
                    n_rep_on  = on_t;
                    n_rep_off = off_eff;
                end
            end
            FUNC_STOP: begin
                n_burst_left = '0;
                n_cont       = 1'b0;
                n_lit        = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lit        <= 1'b0;
            r_elapsed    <= '0;
            r_burst_left <= '0;
            r_cont       <= 1'b0;
            r_phase_on   <= '0;
            r_phase_off  <= '0;
            r_rep_on     <= '0;
            r_rep_off    <= '0;
        end else if (i_en) begin
            r_lit        <= n_lit;
            r_elapsed    <= n_elapsed;
            r_burst_left <= n_burst_left;
            r_cont       <= n_cont;
            r_phase_on   <= n_phase_on;
            r_phase_off  <= n_phase_off;
            r_rep_on     <= n_rep_on;
            r_rep_off    <= n_rep_off;
        end
    end

    // result as seen after the update
    assign o_result.led_on      = n_lit;
    assign o_result.pin_level   = n_lit ? i_active_level : ~i_active_level;
    assign o_result.blinks_left = COUNT_W'(n_burst_left);
    assign o_result.running     = (n_burst_left != '0) || n_cont;

endmodule

### hdl/led_burst_blink_sequencer.sv
// throughput: one item per cycle, stalled only by the output side
// input register -> single-pass blink update -> result register
// one result item for every input item, in order
// reset (synchronous, active low): led dark, counters and times zero,
// active level 1, both pipeline stages empty
// ----------------------------------------------------------------------------
// led_burst_blink_sequencer
// drives one led from 1 ms tick items and burst, continuous and stop commands
// ----------------------------------------------------------------------------
`include "led_burst_blink_sequencer_defines.svh"

module led_burst_blink_sequencer #(
    parameter int TIME_BITS  = 16,
    parameter int COUNT_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // blink_count[7:0], on_ms[23:8], off_ms[39:24]
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    // result item channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // led_on[0], pin_level[1], blinks_left[9:2],
                                        // running[10], zero[15:11]
    // configuration write: active level
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);
    import lbbs_pkg::*;

    logic    r_active_level;
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result core_result;
    logic    out_free;
    logic    advance;

    // config register, written only while the block is idle
    assign o_cfg_ready = !r_in_valid && !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_level <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_active_level <= i_cfg_data;
        end
    end

    // result register frees up when empty or being taken
    assign out_free      = !r_out_valid || m_axis_tready;
    // input register item moves through the update into the result register
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.func        <= t_func'(s_axis_tuser);
            r_in.blink_count <= s_axis_tdata[7:0];
            r_in.on_ms       <= s_axis_tdata[23:8];
            r_in.off_ms      <= s_axis_tdata[39:24];
        end
    end

    // blink state and update, committed when the item advances
    lbbs_core #(
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (advance),
        .i_item         (r_in),
        .i_active_level (r_active_level),
        .o_result       (core_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out.running, r_out.blinks_left,
                            r_out.pin_level, r_out.led_on};

    // pin level is the active level when lit, its inverse when dark
    `LBBS_ASSERT(a_pin_level, r_out_valid |-> (r_out.pin_level == (r_out.led_on ~^ r_active_level)), "pin level does not follow led state")
    // an advancing item always lands in the result register
    `LBBS_ASSERT(a_advance_out, advance |=> r_out_valid, "advanced item lost")
    // a stalled input register keeps its item
    `LBBS_ASSERT(a_in_hold, (r_in_valid && !out_free) |=> r_in_valid, "stalled item dropped")
    // reset empties the result register
    `LBBS_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led burst blink sequencer testbench
// runs a short table of commands and ticks, then random traffic in four
// phases with the active level toggled between them; every result item is
// compared with a typed-in result or an in-bench model of the blinker,
// under bursty input and a stalling output side
// ----------------------------------------------------------------------------
module testbench;
    import lbbs_pkg::*;

    localparam int      RANDOM_PER_PHASE = 460;
    localparam int      PHASES           = 4;
    localparam int      IDLE_LIMIT       = 2000;
    localparam int      DIR_ROWS         = 26;
    localparam t_result RES_DARK_IDLE    = '0;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #2 i_clk = ~i_clk;

    // dut ports, all driven to known values from time zero
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;    // blink_count[7:0], on_ms[23:8], off_ms[39:24]
    logic [1:0]  s_axis_tuser  = FUNC_TICK;    // func[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // led_on[0], pin_level[1], blinks_left[9:2],
                                        // running[10], zero[15:11]
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data    = 1'b0;

    led_burst_blink_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // blinker model: own copy of the led state and the active level
    // ------------------------------------------------------------------
    logic               act_level   = 1'b1;
    logic               lit         = 1'b0;
    logic [MS_W-1:0]    elapsed_ms  = '0;
    logic [COUNT_W-1:0] burst_left  = '0;
    logic               cont_mode   = 1'b0;
    logic [MS_W-1:0]    ph_on_ms    = '0;
    logic [MS_W-1:0]    ph_off_ms   = '0;
    logic [MS_W-1:0]    rep_on_ms   = '0;
    logic [MS_W-1:0]    rep_off_ms  = '0;

    t_result expected_led_q[$];
    int unsigned mismatch_count = 0;

    function automatic t_result advance_blinker(input t_func f, input logic [COUNT_W-1:0] cnt,
                                                input logic [MS_W-1:0] on_t,
                                                input logic [MS_W-1:0] off_t);
        logic [MS_W-1:0] wait_ms;
        logic [MS_W-1:0] off_eff;
        t_result         r;
        off_eff = (off_t != '0) ? off_t : on_t;   // zero off time means reuse on time
        case (f)
            FUNC_TICK: begin
                // idle ticks leave everything alone, elapsed included
                if (burst_left != '0 || cont_mode) begin
                    if (elapsed_ms != '1)
                        elapsed_ms = elapsed_ms + 1'b1;   // saturating
                    wait_ms = lit ? ph_on_ms : ph_off_ms;
                    if (elapsed_ms >= wait_ms) begin
                        elapsed_ms = elapsed_ms - wait_ms;   // carry the excess
                        lit        = ~lit;
                        if (!lit && burst_left != '0) begin
                            burst_left = burst_left - 1'b1;
                            // burst over with continuous mode set: repeat times take over
                            if (burst_left == '0 && cont_mode) begin
                                ph_on_ms  = rep_on_ms;
                                ph_off_ms = rep_off_ms;
                            end
                        end
                    end
                end
            end
            FUNC_BURST, FUNC_CONT: begin
                burst_left = (f == FUNC_BURST) ? cnt : '0;
                ph_on_ms   = on_t;
                ph_off_ms  = off_eff;
                // from dark the led lights on the very next tick
                elapsed_ms = lit ? '0 : off_eff;
                lit        = 1'b0;
                if (f == FUNC_CONT) begin
                    cont_mode  = 1'b1;
                    rep_on_ms  = on_t;
                    rep_off_ms = off_eff;
                end
            end
            default: begin
                // stop keeps times and elapsed
                burst_left = '0;
                cont_mode  = 1'b0;
                lit        = 1'b0;
            end
        endcase
        r.led_on      = lit;
        r.pin_level   = lit ? act_level : ~act_level;
        r.blinks_left = burst_left;
        r.running     = (burst_left != '0) || cont_mode;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // directed table; typed-in results only where obvious
    // ------------------------------------------------------------------
    typedef struct {
        t_func              func;
        logic [COUNT_W-1:0] cnt;
        logic [MS_W-1:0]    on_t;
        logic [MS_W-1:0]    off_t;
        bit                 typed;
        t_result            want;
    } t_dir_row;

    t_dir_row dir_table [DIR_ROWS] = '{
        // tick and stop straight after reset: dark, idle
        '{FUNC_TICK,  8'd0,   16'd0,     16'd0,     1'b1, RES_DARK_IDLE},
        '{FUNC_STOP,  8'd0,   16'd0,     16'd0,     1'b1, RES_DARK_IDLE},
        // two blinks of 1 ms, off time taken from on time
        '{FUNC_BURST, 8'd2,   16'd1,     16'd0,     1'b1, '{1'b1, 8'd2, 1'b0, 1'b0}},
        '{FUNC_TICK,  8'd0,   16'd0,     16'd0,     1'b0, RES_DARK_IDLE},
        '{FUNC_TICK,  8'd0,   16'd0,     16'd0,     1'b0, RES_DARK_IDLE},
        '{FUNC_TICK,  8'd0,   16'd0,     16'd0,     1'b0, RES_DARK_IDLE},
        '{FUNC_TICK,  8'd0,   16'd0,     16'd0,     1'b0, RES_DARK_IDLE},
        '{FUNC_TICK,  8'd0,   16'd0,     16'd0,     1'b0, RES_DARK_IDLE},
        // largest count and times; elapsed saturates on the next tick
        '{FUNC_BURST, 8'd255, 16'hFFFF,  16'hFFFF,  1'b1, '{1'b1, 8'd255, 1'b0, 1'b0}},
        '{FUNC_TICK,  8'd0,   16'd0,     16'd0,     1'b0, RES_DARK_IDLE},
        '{FUNC_TICK,  8'd0,   16'd0,     16'd0,     1'b0, RES_DARK_IDLE},
        // burst of zero blinks stops at once
        '{FUNC_BURST, 8'd0,   16'd0,     16'd0,     1'b1, RES_DARK_IDLE},
        '{FUNC_TICK,  8'd0,   16'd0,     16'd0,     1'b0, RES_DARK_IDLE},
        // continuous with zero wait toggles every tick
        '{FUNC_CONT,  8'd0,   16'd0,     16'd0,     1'b1, '{1'b1, 8'd0, 1'b0, 1'b0}},
        '{FUNC_TICK,  8'd0,   16'd0,     16'd0,     1'b0, RES_DARK_IDLE},
        '{FUNC_TICK,  8'd0,   16'd0,     16'd0,     1'b0, RES_DARK_IDLE},
        // burst on top of continuous, hands back to the repeat times
        '{FUNC_BURST, 8'd3,   16'd2,     16'd1,     1'b0, RES_DARK_IDLE},
        '{FUNC_TICK,  8'd0,   16'd0,     16'd0,     1'b0, RES_DARK_IDLE},
        '{FUNC_TICK,  8'd0,   16'd0,     16'd0,     1'b0, RES_DARK_IDLE},
        '{FUNC_TICK,  8'd0,   16'd0,     16'd0,     1'b0, RES_DARK_IDLE},
        '{FUNC_TICK,  8'd0,   16'd0,     16'd0,     1'b0, RES_DARK_IDLE},
        '{FUNC_TICK,  8'd0,   16'd0,     16'd0,     1'b0, RES_DARK_IDLE},
        '{FUNC_TICK,  8'd0,   16'd0,     16'd0,     1'b0, RES_DARK_IDLE},
        '{FUNC_TICK,  8'd0,   16'd0,     16'd0,     1'b0, RES_DARK_IDLE},
        '{FUNC_TICK,  8'd0,   16'd0,     16'd0,     1'b0, RES_DARK_IDLE},
        // stop clears the count, continuous mode and the led
        '{FUNC_STOP,  8'd0,   16'd0,     16'd0,     1'b1, RES_DARK_IDLE}
    };

    // ------------------------------------------------------------------
    // input side: bursts of items with random gaps
    // ------------------------------------------------------------------
    int unsigned sender_burst = 4;

    task automatic send_item(input t_func f, input logic [COUNT_W-1:0] cnt,
                             input logic [MS_W-1:0] on_t, input logic [MS_W-1:0] off_t,
                             input bit typed, input t_result want);
        t_result predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= {off_t, on_t, cnt};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        predicted = advance_blinker(f, cnt, on_t, off_t);
        expected_led_q.push_back(typed ? want : predicted);
        sender_burst--;
        if (sender_burst == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            // now and then a long stretch without gaps
            sender_burst = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                       : $urandom_range(1, 30);
        end
    endtask

    // mostly short times so blinks complete, with full range and extremes mixed in
    function automatic logic [MS_W-1:0] random_ms();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 82)
            return MS_W'($urandom_range(0, 6));
        else if (sel < 94)
            return MS_W'($urandom_range(0, 65535));
        else if (sel < 97)
            return '0;
        else
            return '1;
    endfunction

    task automatic random_item(output t_func f, output logic [COUNT_W-1:0] cnt,
                               output logic [MS_W-1:0] on_t, output logic [MS_W-1:0] off_t);
        int unsigned sel;
        sel   = $urandom_range(0, 99);
        f     = t_func'((sel < 87) ? FUNC_TICK : (sel < 93) ? FUNC_BURST
                        : (sel < 97) ? FUNC_CONT : FUNC_STOP);
        cnt   = ($urandom_range(0, 4) == 0) ? COUNT_W'($urandom_range(0, 255))
                                            : COUNT_W'($urandom_range(0, 4));
        on_t  = random_ms();
        off_t = ($urandom_range(0, 3) == 0) ? '0 : random_ms();
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_led_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_active_level(input logic lvl);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= lvl;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        act_level = lvl;
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // output side: stall mode changes every window
    // ------------------------------------------------------------------
    int unsigned stall_mode   = 0;
    int unsigned stall_window = 40;
    logic [2:0]  slow_phase   = '0;

    always @(posedge i_clk) begin
        if (stall_window == 0) begin
            stall_mode   <= $urandom_range(0, 2);
            stall_window <= $urandom_range(20, 150);
        end else begin
            stall_window <= stall_window - 1;
        end
        slow_phase <= slow_phase + 1'b1;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;                     // no stalls
            1:       m_axis_tready <= 1'($urandom_range(0, 1)); // coin toss
            default: m_axis_tready <= (slow_phase == '0);       // one in eight
        endcase
    end

    // result check against the oldest expectation
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[10:0]);
            if (expected_led_q.size() == 0) begin
                $error("result item with nothing expected: %h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = expected_led_q.pop_front();
                if (got.led_on !== want.led_on) begin
                    $error("led_on: expected %0d, got %0d", want.led_on, got.led_on);
                    mismatch_count++;
                end
                if (got.pin_level !== want.pin_level) begin
                    $error("pin_level: expected %0d, got %0d", want.pin_level, got.pin_level);
                    mismatch_count++;
                end
                if (got.blinks_left !== want.blinks_left) begin
                    $error("blinks_left: expected %0d, got %0d",
                           want.blinks_left, got.blinks_left);
                    mismatch_count++;
                end
                if (got.running !== want.running) begin
                    $error("running: expected %0d, got %0d", want.running, got.running);
                    mismatch_count++;
                end
                if (m_axis_tdata[15:11] !== '0) begin
                    $error("padding: expected 0, got %h", m_axis_tdata[15:11]);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: too long without any handshake on any channel
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        t_func              f;
        logic [COUNT_W-1:0] cnt;
        logic [MS_W-1:0]    on_t;
        logic [MS_W-1:0]    off_t;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part with the reset active level
        for (int i = 0; i < DIR_ROWS; i++)
            send_item(dir_table[i].func, dir_table[i].cnt, dir_table[i].on_t,
                      dir_table[i].off_t, dir_table[i].typed, dir_table[i].want);

        // random phases, active level 0, 1, 0, 1
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            write_active_level(p[0]);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                random_item(f, cnt, on_t, off_t);
                send_item(f, cnt, on_t, off_t, 1'b0, RES_DARK_IDLE);
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
